FILE: rtl/acsi_disk_command_sequencer_assert.svh
// Assertion macros for the disk command sequencer, used by its executor module
`ifndef ACSI_DISK_COMMAND_SEQUENCER_ASSERT_SVH
`define ACSI_DISK_COMMAND_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define ADCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ADCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/acsi_dcs_pkg.sv
// Types, codes and constants of the disk command sequencer
package acsi_dcs_pkg;

  localparam int COMMAND_BYTES = 10;
  localparam int STORE_IDX_W   = $clog2(COMMAND_BYTES);

  localparam logic [4:0] EXT_PREFIX   = 5'h1f;
  localparam logic [7:0] GROUP1_BASE  = 8'h20;
  localparam logic [3:0] CDB_LEN_G0   = 4'd6;
  localparam logic [3:0] CDB_LEN_G1   = 4'd10;

  // opcodes
  localparam logic [7:0] OP_TEST_READY = 8'h00;
  localparam logic [7:0] OP_REQ_SENSE  = 8'h03;
  localparam logic [7:0] OP_READ       = 8'h08;
  localparam logic [7:0] OP_WRITE      = 8'h0a;
  localparam logic [7:0] OP_INQUIRY    = 8'h12;
  localparam logic [7:0] OP_MODE_SENSE = 8'h1a;
  localparam logic [7:0] OP_READ_CAP   = 8'h25;

  // mode sense pages
  localparam logic [7:0] PAGE_ZERO = 8'h00;
  localparam logic [7:0] PAGE_GEOM = 8'h04;
  localparam logic [7:0] PAGE_ALL  = 8'h3f;

  // reply lengths in bytes
  localparam logic [7:0] SENSE_MIN_LEN = 8'd4;
  localparam logic [7:0] INQUIRY_MAX   = 8'd48;
  localparam logic [7:0] PAGE0_LEN     = 8'd16;
  localparam logic [7:0] PAGE4_LEN     = 8'd24;
  localparam logic [7:0] PAGE_ALL_LEN  = 8'd44;
  localparam logic [7:0] CAPACITY_LEN  = 8'd8;

  localparam logic [4:0] SECTOR_BURST = 5'd31;

  typedef enum logic [1:0] {
    CFG_DISK_PRESENT = 2'd0,
    CFG_SECTOR_COUNT = 2'd1,
    CFG_DEVICE_ID    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RESP_OK     = 2'd0,
    RESP_ERR    = 2'd1,
    RESP_DMA_RD = 2'd2,
    RESP_DMA_WR = 2'd3
  } resp_e;

  typedef enum logic [1:0] {
    SENSE_NONE     = 2'd0,
    SENSE_BAD_OP   = 2'd1,
    SENSE_BAD_ADDR = 2'd2,
    SENSE_BAD_ARG  = 2'd3
  } sense_e;

  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_SENSE_SHORT = 3'd1,
    KIND_SENSE_LONG  = 3'd2,
    KIND_INQUIRY     = 3'd3,
    KIND_PAGE0       = 3'd4,
    KIND_PAGE4       = 3'd5,
    KIND_PAGE_ALL    = 3'd6,
    KIND_CAPACITY    = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ACK    = 3'd1,
    ACT_FAULT  = 3'd2,
    ACT_BAD_OP = 3'd3,
    ACT_EXEC   = 3'd4
  } coll_act_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       a1_flag;
  } in_beat_t;

  typedef struct packed {
    resp_e       response;
    logic        buffer_id;
    logic [4:0]  burst_blocks;
    kind_e       reply_kind;
    logic [7:0]  reply_length;
    sense_e      sense_code;
    logic        addr_in_sense;
    logic [31:0] block_address;
  } out_beat_t;

  // collector to executor: what this beat did, and the opcode, address and count bytes
  typedef struct packed {
    coll_act_e   act;
    logic [7:0]  op;
    logic [23:0] lba;
    logic [7:0]  count;
  } coll_t;

  function automatic logic op_known(input logic [7:0] op);
    op_known = (op == OP_TEST_READY) || (op == OP_REQ_SENSE) || (op == OP_READ) ||
               (op == OP_WRITE) || (op == OP_INQUIRY) || (op == OP_MODE_SENSE) ||
               (op == OP_READ_CAP);
  endfunction

endpackage

FILE: rtl/acsi_dcs_collect.sv
// Command byte collector: prefix, device filter, byte store and completion
module acsi_dcs_collect
  import acsi_dcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       evt_i,
  input  in_beat_t   beat_i,
  input  logic [2:0] device_id_i,
  output coll_t      coll_o
);

  logic [7:0] store_q [COMMAND_BYTES];
  logic [3:0] bi_q, bi_d, bi_nxt;
  logic [3:0] len_q, len_d;
  logic       ext_q, ext_d;
  logic [2:0] sel_q, sel_d;

  logic                   st_we;
  logic [STORE_IDX_W-1:0] st_idx;
  logic [7:0]             st_data;
  logic [7:0]             op_v;
  logic                   dev_hit;
  coll_act_e              act;

  assign op_v    = ext_q ? beat_i.data_byte : {3'b000, beat_i.data_byte[4:0]};
  assign dev_hit = (sel_q == device_id_i);

  always_comb begin
    bi_d    = bi_q;
    len_d   = len_q;
    ext_d   = ext_q;
    sel_d   = sel_q;
    st_we   = 1'b0;
    st_idx  = bi_q[STORE_IDX_W-1:0];
    st_data = beat_i.data_byte;
    act     = ACT_NONE;
    bi_nxt  = dev_hit ? 4'(bi_q + 4'd1) : bi_q;
    if (evt_i) begin
      if (bi_q == '0 && !ext_q && beat_i.a1_flag) begin
        act = ACT_NONE;
      end else if ((bi_q != '0 || ext_q) && !beat_i.a1_flag) begin
        // first byte inside a command: restart, prefix kept
        bi_d = '0;
        act  = ACT_FAULT;
      end else if (bi_q == '0) begin
        if (!ext_q) begin
          sel_d = beat_i.data_byte[7:5];
        end
        if (!ext_q && beat_i.data_byte[7:5] != device_id_i) begin
          act = ACT_NONE;
        end else if (!ext_q && beat_i.data_byte[4:0] == EXT_PREFIX) begin
          ext_d = 1'b1;
          act   = ACT_ACK;
        end else if (!op_known(op_v)) begin
          act = ACT_BAD_OP;
        end else begin
          len_d   = (op_v >= GROUP1_BASE) ? CDB_LEN_G1 : CDB_LEN_G0;
          st_we   = 1'b1;
          st_idx  = '0;
          st_data = op_v;
          bi_d    = 4'd1;
          act     = ACT_ACK;
        end
      end else begin
        st_we = dev_hit && (int'(bi_q) < COMMAND_BYTES);
        if (bi_nxt == len_q) begin
          bi_d  = '0;
          ext_d = 1'b0;
          act   = ACT_EXEC;
        end else begin
          bi_d = bi_nxt;
          act  = ACT_ACK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bi_q  <= '0;
      len_q <= '0;
      ext_q <= 1'b0;
      sel_q <= '0;
    end else begin
      bi_q  <= bi_d;
      len_q <= len_d;
      ext_q <= ext_d;
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < COMMAND_BYTES; i++) begin
      if (st_we && st_idx == STORE_IDX_W'(i)) begin
        store_q[i] <= st_data;
      end
    end
  end

  assign coll_o.act   = act;
  assign coll_o.op    = store_q[0];
  assign coll_o.lba   = {store_q[1], store_q[2], store_q[3]};
  assign coll_o.count = store_q[4];

endmodule

FILE: rtl/acsi_dcs_exec.sv
// Command executor and sector transfer sequencer with sense and address state
`include "acsi_disk_command_sequencer_assert.svh"
module acsi_dcs_exec
  import acsi_dcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        evt_i,
  input  coll_t       coll_i,
  input  logic [31:0] sector_count_i,
  output logic        busy_o,
  output logic        res_vld_o,
  output out_beat_t   res_o
);

  mode_e       mode_q, mode_d;
  logic        buf_q, buf_d;
  logic [7:0]  sl_q, sl_d;
  logic [31:0] addr_q, addr_d;
  sense_e      err_q, err_d;
  logic        ais_q, ais_d;

  logic        go_reply, go_read, go_write;
  kind_e       rep_kind;
  logic [7:0]  rep_len, rep_len_m1;
  logic        keep_sense, keep_addr;
  resp_e       resp;
  logic        res_buf;
  logic [4:0]  res_burst;

  logic [31:0] addr_inc, lba32, lba_inc;
  logic [32:0] lba_end;
  logic        bad_lo, bad_hi;
  logic [7:0]  sense_len, alloc_len, page, sl_dec;
  logic [15:0] alloc16;

  assign busy_o     = (mode_q == MODE_READ) || (mode_q == MODE_WRITE);
  assign addr_inc   = addr_q + 32'd1;
  assign lba32      = {8'd0, coll_i.lba};
  assign lba_inc    = lba32 + 32'd1;
  assign lba_end    = {1'b0, lba32} + {25'd0, coll_i.count};
  assign bad_lo     = (lba32 >= sector_count_i);
  assign bad_hi     = (lba_end > {1'b0, sector_count_i});
  assign sense_len  = (coll_i.count < SENSE_MIN_LEN) ? SENSE_MIN_LEN : coll_i.count;
  assign alloc16    = {coll_i.lba[7:0], coll_i.count};
  assign alloc_len  = (alloc16 > {8'd0, INQUIRY_MAX}) ? INQUIRY_MAX : alloc16[7:0];
  assign page       = coll_i.lba[15:8];
  assign sl_dec     = (sl_q == '0) ? 8'd0 : 8'(sl_q - 8'd1);
  assign rep_len_m1 = 8'(rep_len - 8'd1);

  // datapath and result
  always_comb begin
    buf_d      = buf_q;
    sl_d       = sl_q;
    addr_d     = addr_q;
    err_d      = err_q;
    ais_d      = ais_q;
    go_reply   = 1'b0;
    go_read    = 1'b0;
    go_write   = 1'b0;
    rep_kind   = KIND_NONE;
    rep_len    = '0;
    keep_sense = 1'b0;
    keep_addr  = 1'b0;
    res_vld_o  = 1'b0;
    resp       = RESP_OK;
    res_buf    = 1'b0;
    res_burst  = '0;
    if (evt_i) begin
      unique case (mode_q)
        MODE_READ: begin
          res_vld_o = 1'b1;
          if (sl_q != '0) begin
            addr_d    = addr_inc;
            resp      = RESP_DMA_RD;
            res_buf   = buf_q;
            res_burst = SECTOR_BURST;
            sl_d      = 8'(sl_q - 8'd1);
            if (sl_q != 8'd1) begin
              buf_d = ~buf_q;
            end
          end
        end
        MODE_WRITE: begin
          // next sector goes to the other buffer; shown address is pre-step unless no sector is left
          res_vld_o = 1'b1;
          sl_d      = sl_dec;
          addr_d    = addr_inc;
          buf_d     = ~buf_q;
          if (sl_dec != '0) begin
            resp      = RESP_DMA_WR;
            res_buf   = ~buf_q;
            res_burst = SECTOR_BURST;
            keep_addr = 1'b1;
          end
        end
        default: begin
          unique case (coll_i.act)
            ACT_NONE: ;
            ACT_ACK:  res_vld_o = 1'b1;
            ACT_FAULT: begin
              res_vld_o = 1'b1;
              resp      = RESP_ERR;
            end
            ACT_BAD_OP: begin
              res_vld_o = 1'b1;
              resp      = RESP_ERR;
              err_d     = SENSE_BAD_OP;
              ais_d     = 1'b0;
            end
            ACT_EXEC: begin
              res_vld_o = 1'b1;
              priority case (coll_i.op)
                OP_REQ_SENSE: begin
                  go_reply   = 1'b1;
                  rep_len    = sense_len;
                  rep_kind   = (sense_len <= SENSE_MIN_LEN) ? KIND_SENSE_SHORT
                                                            : KIND_SENSE_LONG;
                  keep_sense = 1'b1;
                  keep_addr  = 1'b1;
                end
                OP_READ: begin
                  addr_d = lba32;
                  sl_d   = coll_i.count;
                  if (bad_lo || bad_hi) begin
                    if (!bad_lo) addr_d = sector_count_i;
                    resp  = RESP_ERR;
                    err_d = SENSE_BAD_ADDR;
                    ais_d = 1'b1;
                  end else begin
                    buf_d = 1'b0;
                    if (coll_i.count != '0) begin
                      go_read   = 1'b1;
                      addr_d    = lba_inc;
                      resp      = RESP_DMA_RD;
                      res_burst = SECTOR_BURST;
                      sl_d      = 8'(coll_i.count - 8'd1);
                      buf_d     = (coll_i.count != 8'd1);
                    end
                  end
                end
                OP_WRITE: begin
                  sl_d = coll_i.count;
                  if (bad_lo || bad_hi) begin
                    addr_d = bad_lo ? lba32 : sector_count_i;
                    resp   = RESP_ERR;
                    err_d  = SENSE_BAD_ADDR;
                    ais_d  = 1'b1;
                  end else begin
                    go_write  = 1'b1;
                    buf_d     = 1'b0;
                    resp      = RESP_DMA_WR;
                    res_burst = SECTOR_BURST;
                  end
                end
                OP_INQUIRY: begin
                  go_reply = 1'b1;
                  rep_kind = KIND_INQUIRY;
                  rep_len  = alloc_len;
                end
                OP_MODE_SENSE: begin
                  priority case (page)
                    PAGE_ZERO: begin
                      go_reply = 1'b1;
                      rep_kind = KIND_PAGE0;
                      rep_len  = PAGE0_LEN;
                    end
                    PAGE_GEOM: begin
                      go_reply = 1'b1;
                      rep_kind = KIND_PAGE4;
                      rep_len  = PAGE4_LEN;
                    end
                    PAGE_ALL: begin
                      go_reply = 1'b1;
                      rep_kind = KIND_PAGE_ALL;
                      rep_len  = PAGE_ALL_LEN;
                    end
                    default: begin
                      resp  = RESP_ERR;
                      err_d = SENSE_BAD_ARG;
                      ais_d = 1'b0;
                    end
                  endcase
                end
                OP_READ_CAP: begin
                  go_reply = 1'b1;
                  rep_kind = KIND_CAPACITY;
                  rep_len  = CAPACITY_LEN;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      endcase
    end
    // reply DMA: one burst from buffer 0, address steps once
    if (go_reply) begin
      resp      = RESP_DMA_RD;
      res_burst = (rep_len == '0) ? 5'd0 : {1'b0, rep_len_m1[7:4]};
      buf_d     = 1'b0;
      addr_d    = addr_inc;
      sl_d      = '0;
      if (keep_sense) begin
        err_d = SENSE_NONE;
        ais_d = 1'b0;
      end
    end
  end

  // transfer state
  always_comb begin
    mode_d = mode_q;
    if (evt_i) begin
      unique case (mode_q)
        MODE_READ:  if (sl_q == '0) mode_d = MODE_IDLE;
        MODE_WRITE: if (sl_q <= 8'd1) mode_d = MODE_IDLE;
        default: begin
          if (go_reply || go_read) begin
            mode_d = MODE_READ;
          end else if (go_write) begin
            mode_d = MODE_WRITE;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_o.response      = resp;
    res_o.buffer_id     = res_buf;
    res_o.burst_blocks  = res_burst;
    res_o.reply_kind    = rep_kind;
    res_o.reply_length  = rep_len;
    res_o.sense_code    = keep_sense ? err_q : err_d;
    res_o.addr_in_sense = keep_sense ? ais_q : ais_d;
    res_o.block_address = keep_addr ? addr_q : addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      buf_q  <= 1'b0;
      sl_q   <= '0;
      addr_q <= '0;
      err_q  <= SENSE_NONE;
      ais_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      buf_q  <= buf_d;
      sl_q   <= sl_d;
      addr_q <= addr_d;
      err_q  <= err_d;
      ais_q  <= ais_d;
    end
  end

  `ADCS_ASSERT_NOW(a_wr_mode_resp, evt_i && mode_q == MODE_WRITE,
    res_o.response == RESP_DMA_WR || res_o.response == RESP_OK, "read DMA during write")
  `ADCS_ASSERT_NEXT(a_reply_step, evt_i && go_reply,
    addr_q == $past(addr_q) + 32'd1 && mode_q == MODE_READ, "reply start lost address step")
  `ADCS_ASSERT_NOW(a_err_plain, res_vld_o && res_o.response == RESP_ERR,
    res_o.burst_blocks == '0 && !res_o.buffer_id, "error status carries DMA fields")
  `ADCS_ASSERT_NEXT(a_wr_end, evt_i && mode_q == MODE_WRITE && sl_q <= 8'd1,
    mode_q == MODE_IDLE, "write transfer did not end")

endmodule

FILE: rtl/acsi_disk_command_sequencer.sv
// Top level of the ACSI disk target command sequencer
// Decode and execute sit between input and result regs; a taken beat waits in the input reg.
// Throughput: one bus event per cycle while the result is not stalled.
// A stalled result holds the next beat in the input register and stalls the input.
// Reset (async, active low) clears config, transfer, sense and collection state.
module acsi_disk_command_sequencer
  import acsi_dcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  // config registers
  logic        disk_present_q;
  logic [31:0] sector_count_q;
  logic [2:0]  device_id_q;

  // input and result beat registers
  logic      in_vld_q;
  in_beat_t  in_beat_q;
  logic      out_vld_q;
  out_beat_t out_beat_q;

  logic      out_free, proc, evt, busy, res_vld;
  coll_t     coll;
  out_beat_t res;

  // the held beat moves on when the result slot is free or draining
  assign out_free   = !out_vld_q || !out_stall_i;
  assign proc       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  // without a disk image every event is swallowed
  assign evt        = proc && disk_present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_present_q <= 1'b0;
      sector_count_q <= '0;
      device_id_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DISK_PRESENT: disk_present_q <= cfg_wdata_i[0];
        CFG_SECTOR_COUNT: sector_count_q <= cfg_wdata_i;
        CFG_DEVICE_ID:    device_id_q    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (proc && res_vld) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_beat_q <= in_data_i;
    end
    if (proc && res_vld) begin
      out_beat_q <= res;
    end
  end

  // byte collection only runs while no sector or reply transfer is under way
  acsi_dcs_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt && !busy),
    .beat_i      (in_beat_q),
    .device_id_i (device_id_q),
    .coll_o      (coll)
  );

  acsi_dcs_exec u_exec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt_i          (evt),
    .coll_i         (coll),
    .sector_count_i (sector_count_q),
    .busy_o         (busy),
    .res_vld_o      (res_vld),
    .res_o          (res)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_beat_q;

endmodule

FILE: sim/tb_acsi_disk_command_sequencer.sv
// Self-checking testbench for the ACSI disk command sequencer
module tb_acsi_disk_command_sequencer;
  import acsi_dcs_pkg::*;

  // Run limit, settle time after the last result, and the long receiver hold-off.
  // The DUT holds a beat in its input register and then its result in the result register, so
  // the settle time covers any beat still inside it when the last expected result has come out.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD     = 80;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_beat_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_beat_t   out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [31:0] cfg_wdata_i = '0;

  acsi_disk_command_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Sequencer state as the testbench sees it, plus its copy of the registers.
  // All of it starts at the reset values; reset is applied once only.
  // ---------------------------------------------------------------------------
  logic        cfg_present = 1'b0;
  logic [31:0] cfg_sectors = '0;
  logic [2:0]  cfg_dev     = '0;

  logic [7:0]  cdb [COMMAND_BYTES] = '{default: 8'h00};
  logic [3:0]  coll_idx      = '0;   // next command byte position
  logic [3:0]  cdb_len       = '0;   // 6 or 10 once the opcode is known
  logic        ext_seen      = 1'b0; // extension prefix taken, opcode byte next
  logic [2:0]  cmd_dev       = '0;   // device field of the last first byte
  mode_e       xfer          = MODE_IDLE;
  logic        buf_sel       = 1'b0;
  logic [7:0]  secs_left     = '0;
  logic [31:0] cur_lba       = '0;
  sense_e      sense_now     = SENSE_NONE;
  logic        sense_has_lba = 1'b0;

  in_beat_t    bus_events[$];        // beats waiting for the driver
  out_beat_t   pending_responses[$]; // predicted results, oldest first

  int unsigned queued_cnt  = 0;
  int unsigned taken_cnt   = 0;
  int unsigned checked_cnt = 0;
  int unsigned fail_cnt    = 0;
  int unsigned cycle_cnt   = 0;

  // A result beat carrying the current sense state and block address
  function automatic out_beat_t beat_now(resp_e r, logic b, logic [4:0] burst,
                                         kind_e k, logic [7:0] len);
    out_beat_t t;
    t.response      = r;
    t.buffer_id     = b;
    t.burst_blocks  = burst;
    t.reply_kind    = k;
    t.reply_length  = len;
    t.sense_code    = sense_now;
    t.addr_in_sense = sense_has_lba;
    t.block_address = cur_lba;
    return t;
  endfunction

  function automatic void raise_sense(sense_e code, logic with_lba);
    sense_now     = code;
    sense_has_lba = with_lba;
    pending_responses.push_back(beat_now(RESP_ERR, 1'b0, 5'd0, KIND_NONE, 8'd0));
  endfunction

  // Reply DMA: one read transfer from buffer 0, block address steps on
  function automatic out_beat_t reply_dma(kind_e k, logic [7:0] len);
    logic [7:0] burst;
    burst   = (len == 8'd0) ? 8'd0 : (len - 8'd1) >> 4;
    xfer    = MODE_READ;
    buf_sel = 1'b0;
    cur_lba = cur_lba + 32'd1;
    secs_left = '0;
    return beat_now(RESP_DMA_RD, 1'b0, burst[4:0], k, len);
  endfunction

  // A sector read DMA has finished: start the next one or close with status
  function automatic void sector_read_done();
    if (secs_left == 8'd0) begin
      xfer = MODE_IDLE;
      pending_responses.push_back(beat_now(RESP_OK, 1'b0, 5'd0, KIND_NONE, 8'd0));
    end else begin
      cur_lba = cur_lba + 32'd1;
      pending_responses.push_back(beat_now(RESP_DMA_RD, buf_sel, SECTOR_BURST,
                                           KIND_NONE, 8'd0));
      secs_left = secs_left - 8'd1;
      if (secs_left != 8'd0) buf_sel = ~buf_sel;
    end
  endfunction

  // A sector write DMA has finished; a zero count closes on the first one
  function automatic void sector_write_done();
    if (secs_left != 8'd0) secs_left = secs_left - 8'd1;
    if (secs_left != 8'd0)
      pending_responses.push_back(beat_now(RESP_DMA_WR, ~buf_sel, SECTOR_BURST,
                                           KIND_NONE, 8'd0));
    cur_lba = cur_lba + 32'd1;
    buf_sel = ~buf_sel;
    if (secs_left == 8'd0) begin
      xfer = MODE_IDLE;
      pending_responses.push_back(beat_now(RESP_OK, 1'b0, 5'd0, KIND_NONE, 8'd0));
    end
  endfunction

  function automatic logic known_opcode(logic [7:0] op);
    case (op)
      OP_TEST_READY, OP_REQ_SENSE, OP_READ, OP_WRITE,
      OP_INQUIRY, OP_MODE_SENSE, OP_READ_CAP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic range_bad(logic [23:0] lba, logic [7:0] cnt);
    logic [32:0] span;
    span = {9'd0, lba} + {25'd0, cnt};
    return ({8'd0, lba} >= cfg_sectors) || (span > {1'b0, cfg_sectors});
  endfunction

  // A complete command sits in the store: work out its answer
  function automatic void run_command();
    logic [7:0]  op;
    logic [7:0]  cnt;
    logic [31:0] lba;
    logic [15:0] alloc;
    logic [7:0]  len;
    sense_e      old_code;
    logic        old_flag;
    logic [31:0] old_lba;
    out_beat_t   b;
    op  = cdb[0];
    lba = {8'd0, cdb[1], cdb[2], cdb[3]};
    cnt = cdb[4];
    case (op)
      OP_REQ_SENSE: begin
        // the reply shows the sense as it was, before clearing and address step
        len      = (cnt < 8'd4) ? 8'd4 : cnt;
        old_code = sense_now;
        old_flag = sense_has_lba;
        old_lba  = cur_lba;
        if (len <= 8'd4) b = reply_dma(KIND_SENSE_SHORT, len);
        else b = reply_dma(KIND_SENSE_LONG, len);
        b.sense_code    = old_code;
        b.addr_in_sense = old_flag;
        b.block_address = old_lba;
        sense_now       = SENSE_NONE;
        sense_has_lba   = 1'b0;
        pending_responses.push_back(b);
      end
      OP_READ: begin
        cur_lba   = lba;
        secs_left = cnt;
        if (lba >= cfg_sectors) begin
          raise_sense(SENSE_BAD_ADDR, 1'b1);
        end else if (range_bad(lba[23:0], cnt)) begin
          cur_lba = cfg_sectors;
          raise_sense(SENSE_BAD_ADDR, 1'b1);
        end else begin
          xfer    = MODE_READ;
          buf_sel = 1'b0;
          sector_read_done();
        end
      end
      OP_WRITE: begin
        // a good write leaves the block address where it was
        secs_left = cnt;
        if (lba >= cfg_sectors) begin
          cur_lba = lba;
          raise_sense(SENSE_BAD_ADDR, 1'b1);
        end else if (range_bad(lba[23:0], cnt)) begin
          cur_lba = cfg_sectors;
          raise_sense(SENSE_BAD_ADDR, 1'b1);
        end else begin
          xfer    = MODE_WRITE;
          buf_sel = 1'b0;
          pending_responses.push_back(beat_now(RESP_DMA_WR, 1'b0, SECTOR_BURST,
                                               KIND_NONE, 8'd0));
        end
      end
      OP_INQUIRY: begin
        alloc = {cdb[3], cnt};
        if (alloc > 16'd48) alloc = 16'd48;
        pending_responses.push_back(reply_dma(KIND_INQUIRY, alloc[7:0]));
      end
      OP_MODE_SENSE: begin
        case (cdb[2])
          PAGE_ZERO: pending_responses.push_back(reply_dma(KIND_PAGE0, 8'd16));
          PAGE_GEOM: pending_responses.push_back(reply_dma(KIND_PAGE4, 8'd24));
          PAGE_ALL:  pending_responses.push_back(reply_dma(KIND_PAGE_ALL, 8'd44));
          default:   raise_sense(SENSE_BAD_ARG, 1'b0);
        endcase
      end
      OP_READ_CAP: pending_responses.push_back(reply_dma(KIND_CAPACITY, 8'd8));
      default: pending_responses.push_back(beat_now(RESP_OK, 1'b0, 5'd0, KIND_NONE, 8'd0));
    endcase
  endfunction

  // One accepted bus beat: a command byte, or a DMA completion mid-transfer
  function automatic void apply_bus_event(in_beat_t ev);
    logic [7:0] op;
    if (!cfg_present) return;
    if (xfer == MODE_READ) begin
      sector_read_done();
      return;
    end
    if (xfer == MODE_WRITE) begin
      sector_write_done();
      return;
    end
    // following byte with no command open: dropped silently
    if (coll_idx == 4'd0 && !ext_seen && ev.a1_flag) return;
    // stray first byte inside a command: error, collection restarts, prefix kept
    if ((coll_idx != 4'd0 || ext_seen) && !ev.a1_flag) begin
      coll_idx = 4'd0;
      pending_responses.push_back(beat_now(RESP_ERR, 1'b0, 5'd0, KIND_NONE, 8'd0));
      return;
    end
    if (coll_idx == 4'd0) begin
      op = ev.data_byte;
      if (!ext_seen) begin
        cmd_dev = ev.data_byte[7:5];
        if (cmd_dev != cfg_dev) return;
        op = {3'd0, ev.data_byte[4:0]};
        if (op[4:0] == EXT_PREFIX) begin
          ext_seen = 1'b1;
          pending_responses.push_back(beat_now(RESP_OK, 1'b0, 5'd0, KIND_NONE, 8'd0));
          return;
        end
      end
      if (!known_opcode(op)) begin
        raise_sense(SENSE_BAD_OP, 1'b0);
        return;
      end
      cdb_len  = (op >= 8'h20) ? 4'd10 : 4'd6;
      cdb[0]   = op;
      coll_idx = 4'd1;
    end else if (cmd_dev == cfg_dev) begin
      if (coll_idx < COMMAND_BYTES) cdb[coll_idx] = ev.data_byte;
      coll_idx = coll_idx + 4'd1;
    end
    if (coll_idx == cdb_len) begin
      coll_idx = 4'd0;
      ext_seen = 1'b0;
      run_command();
    end else begin
      pending_responses.push_back(beat_now(RESP_OK, 1'b0, 5'd0, KIND_NONE, 8'd0));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued beats, with a random gap after each accepted one.
  // Sixty beats in every three hundred run back to back.
  // Prediction is done here, at the edge where the beat is taken.
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;
  int unsigned gap_draw;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      apply_bus_event(in_data_i);
      taken_cnt++;
      gap_draw = ((taken_cnt % 300) < 60) ? 0 : $urandom_range(0, 5);
      if (gap_draw == 0 && bus_events.size() != 0) begin
        in_data_i <= bus_events.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        gap_left = gap_draw;
      end
    end else if (!in_valid_i) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (bus_events.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= bus_events.pop_front();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result beat against the oldest prediction, then
  // stalls for a random stretch. Now and then it holds off for a long stretch so the
  // sequencer backs up and stalls its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  out_beat_t   want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_responses.size() == 0) begin
          if (fail_cnt < 10)
            $display("result %0d: none predicted, got resp=%0d addr=%h", checked_cnt,
                     out_data_o.response, out_data_o.block_address);
          fail_cnt++;
        end else begin
          want = pending_responses.pop_front();
          if (out_data_o.response      !== want.response      ||
              out_data_o.buffer_id     !== want.buffer_id     ||
              out_data_o.burst_blocks  !== want.burst_blocks  ||
              out_data_o.reply_kind    !== want.reply_kind    ||
              out_data_o.reply_length  !== want.reply_length  ||
              out_data_o.sense_code    !== want.sense_code    ||
              out_data_o.addr_in_sense !== want.addr_in_sense ||
              out_data_o.block_address !== want.block_address) begin
            if (fail_cnt < 10) begin
              $display("result %0d: expected resp=%0d buf=%0d burst=%0d kind=%0d len=%0d",
                       checked_cnt, want.response, want.buffer_id, want.burst_blocks,
                       want.reply_kind, want.reply_length);
              $display("  sense=%0d lba_flag=%0d addr=%h", want.sense_code,
                       want.addr_in_sense, want.block_address);
              $display("  got resp=%0d buf=%0d burst=%0d kind=%0d len=%0d",
                       out_data_o.response, out_data_o.buffer_id, out_data_o.burst_blocks,
                       out_data_o.reply_kind, out_data_o.reply_length);
              $display("  sense=%0d lba_flag=%0d addr=%h", out_data_o.sense_code,
                       out_data_o.addr_in_sense, out_data_o.block_address);
            end
            fail_cnt++;
          end
        end
        checked_cnt++;
        if (checked_cnt % 400 == 150) stall_left = LONG_HOLD;
        else if (checked_cnt % 250 < 50) stall_left = 0;
        else stall_left = $urandom_range(0, 5);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d predictions open", cycle_cnt,
               pending_responses.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put(logic [7:0] d, logic a1);
    in_beat_t b;
    b.data_byte = d;
    b.a1_flag   = a1;
    bus_events.push_back(b);
    queued_cnt++;
  endtask

  // DMA completions a well-formed command needs before the target is idle again
  function automatic int completions_for(logic [7:0] op, logic [23:0] lba, logic [7:0] cnt);
    case (op)
      OP_READ:  return range_bad(lba, cnt) ? 0 : int'(cnt);
      OP_WRITE: return range_bad(lba, cnt) ? 0 : ((cnt == 8'd0) ? 1 : int'(cnt));
      OP_REQ_SENSE, OP_INQUIRY, OP_READ_CAP: return 1;
      OP_MODE_SENSE:
        return (lba[15:8] == PAGE_ZERO || lba[15:8] == PAGE_GEOM ||
                lba[15:8] == PAGE_ALL) ? 1 : 0;
      default: return 0;
    endcase
  endfunction

  // Whole command, with prefix if asked or if the opcode needs ten bytes,
  // followed by the completions it will wait for
  task automatic send_command(logic [2:0] dev, logic [7:0] op, logic [23:0] lba,
                              logic [7:0] cnt, logic with_prefix);
    int n_bytes;
    int tail;
    if (with_prefix || op >= 8'h20) begin
      put({dev, EXT_PREFIX}, 1'b0);
      put(op, 1'b1);
    end else begin
      put({dev, op[4:0]}, 1'b0);
    end
    n_bytes = (op >= 8'h20) ? 9 : 5;
    put(lba[23:16], 1'b1);
    put(lba[15:8], 1'b1);
    put(lba[7:0], 1'b1);
    put(cnt, 1'b1);
    for (int i = 4; i < n_bytes; i++) put(8'($urandom_range(0, 255)), 1'b1);
    tail = (dev == cfg_dev && cfg_present && known_opcode(op)) ?
           completions_for(op, lba, cnt) : 0;
    for (int i = 0; i < tail; i++)
      put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [23:0] pick_lba();
    logic [31:0] top;
    case ($urandom_range(0, 5))
      0, 1: return 24'($urandom_range(0, 24'hffffff));
      2:    return 24'h000000;
      3:    return 24'hffffff;
      default: begin
        // just inside or just past the end of the disk
        top = (cfg_sectors > 32'hffffff) ? 32'hffffff : cfg_sectors;
        if (top > 32'd8) return 24'(top - $urandom_range(0, 8));
        return 24'($urandom_range(0, top));
      end
    endcase
  endfunction

  // Mostly whole commands with random content; the rest bad opcodes,
  // commands cut short by a stray first byte, and loose noise
  task automatic random_traffic(int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    logic [2:0]  dev;
    logic [7:0]  op;
    logic [23:0] lba;
    logic [7:0]  cnt;
    stop_at = queued_cnt + n_items;
    while (queued_cnt < stop_at) begin
      r   = $urandom_range(0, 99);
      dev = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : cfg_dev;
      if (r < 72) begin
        case ($urandom_range(0, 6))
          0: op = OP_TEST_READY;
          1: op = OP_REQ_SENSE;
          2: op = OP_READ;
          3: op = OP_WRITE;
          4: op = OP_INQUIRY;
          5: op = OP_MODE_SENSE;
          default: op = OP_READ_CAP;
        endcase
        lba = pick_lba();
        cnt = ($urandom_range(0, 79) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 5));
        if (op == OP_INQUIRY) begin
          lba[7:0] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
          cnt      = 8'($urandom_range(0, 255));
        end else if (op == OP_REQ_SENSE) begin
          cnt = 8'($urandom_range(0, 255));
        end else if (op == OP_MODE_SENSE) begin
          case ($urandom_range(0, 4))
            0: lba[15:8] = PAGE_ZERO;
            1: lba[15:8] = PAGE_GEOM;
            2: lba[15:8] = PAGE_ALL;
            default: lba[15:8] = 8'($urandom_range(0, 255));
          endcase
        end
        send_command(dev, op, lba, cnt, $urandom_range(0, 3) == 0);
      end else if (r < 80) begin
        if ($urandom_range(0, 3) == 0) begin
          do op = 8'($urandom_range(0, 255)); while (known_opcode(op));
          send_command(dev, op, 24'($urandom_range(0, 24'hffffff)),
                       8'($urandom_range(0, 255)), 1'b1);
        end else begin
          do op = 8'($urandom_range(0, 31));
          while (known_opcode(op) || op[4:0] == EXT_PREFIX);
          send_command(dev, op, 24'($urandom_range(0, 24'hffffff)),
                       8'($urandom_range(0, 255)), 1'b0);
        end
      end else if (r < 90) begin
        put({dev, OP_READ[4:0]}, 1'b0);
        repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 255)), 1'b1);
        put(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4))
          put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Sender holds back until every beat is taken and every result is in,
  // then waits out the pipeline in case the last beats gave no result
  task automatic settle();
    while (taken_cnt != queued_cnt || pending_responses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Called just after the clock has risen, with the sequencer idle
  task automatic set_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_DISK_PRESENT: cfg_present = val[0];
      CFG_SECTOR_COUNT: cfg_sectors = val;
      default:          cfg_dev     = val[2:0];
    endcase
  endtask

  task automatic run_phase(logic [31:0] sectors, logic [2:0] dev, int unsigned n_items);
    set_reg(CFG_SECTOR_COUNT, sectors);
    set_reg(CFG_DEVICE_ID, {29'd0, dev});
    random_traffic(n_items);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // no disk attached yet: everything is dropped
    repeat (20) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    settle();

    set_reg(CFG_DISK_PRESENT, 32'd1);
    set_reg(CFG_SECTOR_COUNT, 32'h100);
    set_reg(CFG_DEVICE_ID, 32'd0);

    // other device's command, then its following byte, both ignored
    put({3'd1, OP_TEST_READY[4:0]}, 1'b0);
    put(8'hff, 1'b1);
    // unknown opcode
    put({3'd0, 5'h05}, 1'b0);
    // stray first byte part way through a read
    put({3'd0, OP_READ[4:0]}, 1'b0);
    put(8'h00, 1'b1);
    put(8'h00, 1'b0);
    // zero-count read ends at once; zero-count write on the last sector
    send_command(3'd0, OP_READ, 24'h000000, 8'd0, 1'b0);
    send_command(3'd0, OP_WRITE, 24'h0000ff, 8'd0, 1'b0);
    // ten-byte command behind the prefix
    send_command(3'd0, OP_READ_CAP, 24'h000000, 8'd0, 1'b1);
    // top address and count: out of range, then fetch the long sense
    send_command(3'd0, OP_READ, 24'hffffff, 8'hff, 1'b0);
    send_command(3'd0, OP_REQ_SENSE, 24'h000000, 8'hff, 1'b0);
    settle();

    run_phase(32'hffffffff, 3'd7, 220);
    run_phase(32'h00000000, 3'd3, 150);
    run_phase($urandom_range(1, 32'h200), 3'($urandom_range(0, 7)), 250);
    run_phase(32'h01000000, 3'd5, 200);

    // detach and reattach the disk
    set_reg(CFG_DISK_PRESENT, 32'd0);
    repeat (20) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    settle();
    set_reg(CFG_DISK_PRESENT, 32'd1);
    run_phase(32'h100, 3'd0, 230);

    fail_cnt += pending_responses.size();
    $display("%0d bus beats driven over seven register settings, %0d results checked",
             taken_cnt, checked_cnt);
    $display("%0d failures in all", fail_cnt);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
